>>> rtl/assert_macros.svh
// Assertion macros shared by the filter RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

>>> rtl/ftpf_pkg.sv
// Package: constants and types for the five-tuple packet filter
`timescale 1ns / 1ps
package ftpf_pkg;
   localparam int RULE_SLOTS_DEF = 1024;
   localparam logic [1:0] CMD_WRITE    = 2'd0;
   localparam logic [1:0] CMD_REMOVE   = 2'd1;
   localparam logic [1:0] CMD_CLASSIFY = 2'd2;
   localparam logic [2:0] FC_ETH_SHORT = 3'd0;
   localparam logic [2:0] FC_NON_IP    = 3'd1;
   localparam logic [2:0] FC_IP_SHORT  = 3'd2;
   localparam logic [2:0] FC_IPV4      = 3'd3;
   localparam logic [2:0] FC_IPV6      = 3'd4;
   localparam logic [2:0] FC_V4_L4S    = 3'd5;
   localparam logic [2:0] FC_V6_L4S    = 3'd6;
   localparam logic [2:0] FC_UNDEF     = 3'd7;
   localparam logic [7:0] PROTO_TCP = 8'd6;
   localparam logic [7:0] PROTO_UDP = 8'd17;
   localparam logic [63:0] V4_MAPPED_TAG = 64'h0000_ffff_0000_0000;
   localparam int RULE_W = 64 * 4 + 16 + 16 + 8 + 32 + 1;

   typedef struct packed {
      logic [63:0] src_high;
      logic [63:0] src_low;
      logic [63:0] dst_high;
      logic [63:0] dst_low;
      logic [15:0] sport;
      logic [15:0] dport;
      logic [7:0]  proto;
      logic [31:0] prio;
      logic        action;
   } rule_type;
endpackage

>>> rtl/ftpf_ram.sv
// Generic single-port-write, single-read RAM with registered read
`timescale 1ns / 1ps
module ftpf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

>>> rtl/five_tuple_priority_packet_filter_top.sv
// Top level: five-tuple priority packet filter with a scanned rule table
//
// Usage
//   req_ channel carries one command word: write rule, remove rule or
//   classify. rsp_ channel returns one word per command: verdict, rule_hit
//   and hit_slot. Both use valid/stall; a word moves when valid is high and
//   stall is low.
//   Write, remove, unknown commands and classifies decided by frame class
//   or protocol are resolved in EXEC and present their registered result in RESP.
//   A classify that needs the table reads one rule slot per cycle from the
//   single read port of the rule memory, scanning slots 0 to RULE_SLOTS - 1,
//   and presents its result word after the DRAIN state. One command is in
//   flight at a time; the next is taken in the cycle after the result word
//   leaves.
//   Reset clears every slot-valid flag (flip-flops when RULE_SLOTS <= 256,
//   else a clearing pass over every entry, RULE_SLOTS rounded up to a
//   power of two, during which req_stall stays high). Rule contents are not
//   cleared.
//   When the receiver stalls the result stays in the output register and
//   no new command is taken until it has gone.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module five_tuple_priority_packet_filter_top #(
   parameter int RULE_SLOTS = ftpf_pkg::RULE_SLOTS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_cmd,
   input  logic [9:0]  req_rule_slot,
   input  logic [63:0] req_source_high,
   input  logic [63:0] req_source_low,
   input  logic [63:0] req_dest_high,
   input  logic [63:0] req_dest_low,
   input  logic [15:0] req_source_port,
   input  logic [15:0] req_dest_port,
   input  logic [7:0]  req_proto_number,
   input  logic [31:0] req_rule_priority,
   input  logic        req_rule_action,
   input  logic [2:0]  req_frame_class,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_verdict,
   output logic        rsp_rule_hit,
   output logic [9:0]  rsp_hit_slot
);
   localparam int AW = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
   localparam int DEPTH = 1 << AW;
   localparam int CW = AW + 1;
   localparam bit VFF = (RULE_SLOTS <= 256);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_EXEC  = 3'd2;
   localparam logic [2:0] ST_SCAN  = 3'd3;
   localparam logic [2:0] ST_DRAIN = 3'd4;
   localparam logic [2:0] ST_RESP  = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   ftpf_pkg::rule_type key_ff, key_in;
   logic [1:0]  cmd_ff, cmd_in;
   logic [9:0]  slot_ff, slot_in;
   logic [2:0]  cls_ff, cls_in;

   logic        best_any_ff, best_any_in;
   logic [31:0] best_prio_ff, best_prio_in;
   logic        best_act_ff, best_act_in;
   logic [9:0]  best_slot_ff, best_slot_in;

   logic        rd_live_ff, rd_live_in;
   logic [AW-1:0] rd_idx_ff, rd_idx_in;

   logic        out_verdict_ff, out_verdict_in;
   logic        out_hit_ff, out_hit_in;
   logic [9:0]  out_slot_ff, out_slot_in;

   logic        accept, in_range;
   logic [AW-1:0] slot_idx;

   logic        rule_we;
   logic [AW-1:0] rule_wa, rule_ra;
   ftpf_pkg::rule_type rule_wd, rule_rd;

   logic        vld_we, vld_wd, vld_rd;
   logic [AW-1:0] vld_wa, vld_ra;

   logic        m_src, m_dst, m_ok;
   logic        l4;

   assign accept   = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_RESP);
   assign rsp_verdict  = out_verdict_ff;
   assign rsp_rule_hit = out_hit_ff;
   assign rsp_hit_slot = out_slot_ff;

   assign in_range = ({{(32-10){1'b0}}, slot_ff} < 32'(RULE_SLOTS));
   assign slot_idx = AW'(slot_ff);
   assign l4 = (key_ff.proto == ftpf_pkg::PROTO_TCP) || (key_ff.proto == ftpf_pkg::PROTO_UDP);

   assign rule_we = (state_ff == ST_EXEC) && (cmd_ff == ftpf_pkg::CMD_WRITE) && in_range;
   assign rule_wa = slot_idx;
   assign rule_wd = key_ff;
   assign rule_ra = cnt_ff[AW-1:0];

   ftpf_ram #(.WIDTH(ftpf_pkg::RULE_W), .DEPTH(DEPTH)) u_rule_ram (
      .clock  (clock),
      .wr_en  (rule_we),
      .wr_addr(rule_wa),
      .wr_data(rule_wd),
      .rd_addr(rule_ra),
      .rd_data(rule_rd)
   );

   assign vld_ra = cnt_ff[AW-1:0];
   always_comb begin
      vld_we = 1'b0;
      vld_wa = slot_idx;
      vld_wd = 1'b0;
      if (state_ff == ST_CLEAR) begin
         vld_we = 1'b1;
         vld_wa = cnt_ff[AW-1:0];
      end else if (state_ff == ST_EXEC && in_range &&
                   (cmd_ff == ftpf_pkg::CMD_WRITE || cmd_ff == ftpf_pkg::CMD_REMOVE)) begin
         vld_we = 1'b1;
         vld_wd = (cmd_ff == ftpf_pkg::CMD_WRITE);
      end
   end

   generate
      if (VFF) begin : g_vff
         logic [DEPTH-1:0] vbits_ff;
         always_ff @(posedge clock) begin
            if (reset) begin
               vbits_ff <= '0;
            end else if (vld_we) begin
               vbits_ff[vld_wa] <= vld_wd;
            end
         end
         logic vrd_ff;
         always_ff @(posedge clock) begin
            vrd_ff <= vbits_ff[vld_ra];
         end
         assign vld_rd = vrd_ff;
      end else begin : g_vram
         ftpf_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_vld_ram (
            .clock  (clock),
            .wr_en  (vld_we),
            .wr_addr(vld_wa),
            .wr_data(vld_wd),
            .rd_addr(vld_ra),
            .rd_data(vld_rd)
         );
      end
   endgenerate

   always_comb begin
      m_src = ((rule_rd.src_high == '0) && (rule_rd.src_low == '0)) ||
              ((rule_rd.src_high == key_ff.src_high) && (rule_rd.src_low == key_ff.src_low));
      m_dst = ((rule_rd.dst_high == '0) && (rule_rd.dst_low == '0)) ||
              ((rule_rd.dst_high == key_ff.dst_high) && (rule_rd.dst_low == key_ff.dst_low));
      m_ok = vld_rd && m_src && m_dst &&
             ((rule_rd.sport == '0) || (rule_rd.sport == key_ff.sport)) &&
             ((rule_rd.dport == '0) || (rule_rd.dport == key_ff.dport)) &&
             ((rule_rd.proto == '0) || (rule_rd.proto == key_ff.proto));
   end

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      key_in = key_ff;
      cmd_in = cmd_ff;
      slot_in = slot_ff;
      cls_in = cls_ff;
      best_any_in = best_any_ff;
      best_prio_in = best_prio_ff;
      best_act_in = best_act_ff;
      best_slot_in = best_slot_ff;
      rd_live_in = 1'b0;
      rd_idx_in = rd_idx_ff;
      out_verdict_in = out_verdict_ff;
      out_hit_in = out_hit_ff;
      out_slot_in = out_slot_ff;

      if (rd_live_ff && m_ok && (!best_any_ff || rule_rd.prio >= best_prio_ff)) begin
         best_any_in = 1'b1;
         best_prio_in = rule_rd.prio;
         best_act_in = rule_rd.action;
         best_slot_in = 10'(rd_idx_ff);
      end

      unique case (state_ff)
         ST_CLEAR: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(DEPTH - 1)) begin
               state_in = ST_IDLE;
               cnt_in = '0;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               cmd_in = req_cmd;
               slot_in = req_rule_slot;
               cls_in = req_frame_class;
               key_in.src_high = req_source_high;
               key_in.src_low = req_source_low;
               key_in.dst_high = req_dest_high;
               key_in.dst_low = req_dest_low;
               if (req_frame_class == ftpf_pkg::FC_IPV4 &&
                   req_cmd == ftpf_pkg::CMD_CLASSIFY) begin
                  key_in.src_high = '0;
                  key_in.src_low = ftpf_pkg::V4_MAPPED_TAG | {32'd0, req_source_low[31:0]};
                  key_in.dst_high = '0;
                  key_in.dst_low = ftpf_pkg::V4_MAPPED_TAG | {32'd0, req_dest_low[31:0]};
               end
               key_in.sport = req_source_port;
               key_in.dport = req_dest_port;
               key_in.proto = req_proto_number;
               key_in.prio = req_rule_priority;
               key_in.action = req_rule_action;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            out_verdict_in = 1'b0;
            out_hit_in = 1'b0;
            out_slot_in = '0;
            state_in = ST_RESP;
            if (cmd_ff == ftpf_pkg::CMD_CLASSIFY) begin
               priority if (cls_ff == ftpf_pkg::FC_ETH_SHORT ||
                            cls_ff == ftpf_pkg::FC_IP_SHORT) begin
                  out_verdict_in = 1'b0;
               end else if (cls_ff == ftpf_pkg::FC_NON_IP || cls_ff == ftpf_pkg::FC_UNDEF) begin
                  out_verdict_in = 1'b1;
               end else if (!l4) begin
                  out_verdict_in = 1'b1;
               end else if (cls_ff == ftpf_pkg::FC_V4_L4S || cls_ff == ftpf_pkg::FC_V6_L4S) begin
                  out_verdict_in = 1'b0;
               end else begin
                  best_any_in = 1'b0;
                  best_prio_in = '0;
                  best_act_in = 1'b0;
                  best_slot_in = '0;
                  cnt_in = '0;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            rd_live_in = 1'b1;
            rd_idx_in = cnt_ff[AW-1:0];
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(RULE_SLOTS - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!rd_live_ff) begin
               out_verdict_in = best_act_ff;
               out_hit_in = best_any_ff;
               out_slot_in = best_slot_ff;
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= VFF ? ST_IDLE : ST_CLEAR;
         cnt_ff <= '0;
         rd_live_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         rd_live_ff <= rd_live_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      cmd_ff <= cmd_in;
      slot_ff <= slot_in;
      cls_ff <= cls_in;
      best_any_ff <= best_any_in;
      best_prio_ff <= best_prio_in;
      best_act_ff <= best_act_in;
      best_slot_ff <= best_slot_in;
      rd_idx_ff <= rd_idx_in;
      out_verdict_ff <= out_verdict_in;
      out_hit_ff <= out_hit_in;
      out_slot_ff <= out_slot_in;
   end

   `ASSERT_IMP(a_no_hit_slot, clock, reset, rsp_valid && !rsp_rule_hit, rsp_hit_slot == '0, "hit_slot set without a hit")
   `ASSERT_IMP(a_one_side, clock, reset, rsp_valid, req_stall, "command taken while a word waits")
   `ASSERT_NEXT(a_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_hit_slot), "stalled word changed")
   `ASSERT_IMP(a_read_in_scan, clock, reset, rd_live_ff, state_ff == ST_SCAN || state_ff == ST_DRAIN, "read outside scan")
endmodule
